// ===== rtl/ofdf_pkg.sv =====
`default_nettype none

package ofdf_pkg;

   // Field widths
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int MOV_W   = 3;
   localparam int FIXED_W = 5;
   localparam int EMON_W  = 3;
   localparam int DOY_W   = 9;

   // Fixed feast table
   localparam int FIXED_FEASTS_DEF = 19;
   localparam int TABLE_SLOTS      = 32;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Reciprocals for quotient estimates (floor(2^16 / divisor))
   localparam int RECIP_SHIFT = 16;
   localparam logic [27:0] RECIP_19 = 28'd3449;
   localparam logic [27:0] RECIP_7  = 28'd9362;
   localparam logic [27:0] RECIP_25 = 28'd2621;

   // Movable feast codes
   localparam logic [MOV_W-1:0] MOV_NONE   = 3'd0;
   localparam logic [MOV_W-1:0] MOV_EASTER = 3'd1;
   localparam logic [MOV_W-1:0] MOV_M48    = 3'd2;
   localparam logic [MOV_W-1:0] MOV_M47    = 3'd3;
   localparam logic [MOV_W-1:0] MOV_M7     = 3'd4;
   localparam logic [MOV_W-1:0] MOV_P39    = 3'd5;
   localparam logic [MOV_W-1:0] MOV_P49    = 3'd6;
   localparam logic [MOV_W-1:0] MOV_P57    = 3'd7;

   localparam logic [FIXED_W-1:0] FIXED_NONE = 5'd0;

   // Easter months
   localparam logic [EMON_W-1:0] MON_APRIL = 3'd4;
   localparam logic [EMON_W-1:0] MON_MAY   = 3'd5;

   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;

   typedef struct packed {
      logic [DAY_W-1:0]   mday;
      logic [MONTH_W-1:0] mon;
   } ofdf_feast_type;

   localparam ofdf_feast_type FEAST_TABLE [TABLE_SLOTS] = '{
      '{5'd7,  4'd1},  '{5'd14, 4'd1},  '{5'd19, 4'd1},  '{5'd15, 4'd2},
      '{5'd25, 4'd2},  '{5'd7,  4'd4},  '{5'd5,  4'd5},  '{5'd7,  4'd7},
      '{5'd12, 4'd7},  '{5'd14, 4'd8},  '{5'd19, 4'd8},  '{5'd28, 4'd8},
      '{5'd11, 4'd9},  '{5'd21, 4'd9},  '{5'd27, 4'd9},  '{5'd14, 4'd10},
      '{5'd4,  4'd11}, '{5'd28, 4'd11}, '{5'd4,  4'd12}, '{5'd0,  4'd0},
      '{5'd0,  4'd0},  '{5'd0,  4'd0},  '{5'd0,  4'd0},  '{5'd0,  4'd0},
      '{5'd0,  4'd0},  '{5'd0,  4'd0},  '{5'd0,  4'd0},  '{5'd0,  4'd0},
      '{5'd0,  4'd0},  '{5'd0,  4'd0},  '{5'd0,  4'd0},  '{5'd0,  4'd0}
   };

   // Queue entry: the date, quotient estimates and the fixed feast match
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [7:0]         q19;
      logic [9:0]         q7;
      logic [7:0]         q25;
      logic [FIXED_W-1:0] fixed;
   } ofdf_item_type;

   // Back stage one: residues (d, b, c), leap, date check, day of year
   typedef struct packed {
      logic [4:0]         d;
      logic [1:0]         b;
      logic [2:0]         c;
      logic               leap;
      logic               date_ok;
      logic [DOY_W-1:0]   doy;
      logic [FIXED_W-1:0] fixed;
   } ofdf_stage_type;

   // Queue status toward the front
   typedef struct packed {
      logic full;
      logic empty;
   } ofdf_qstat_type;

   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] mon);
      logic [DOY_W-1:0] v;
      case (mon)
         4'd1:    v = 9'd0;
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] v;
      case (mon)
         4'd2:    v = leap ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   v = 5'd30;
         default: v = 5'd31;
      endcase
      return v;
   endfunction

   // (19a + 15) mod 30 for a = 0..18
   function automatic logic [4:0] d_of(input logic [4:0] a);
      logic [4:0] v;
      case (a)
         5'd0:    v = 5'd15;
         5'd1:    v = 5'd4;
         5'd2:    v = 5'd23;
         5'd3:    v = 5'd12;
         5'd4:    v = 5'd1;
         5'd5:    v = 5'd20;
         5'd6:    v = 5'd9;
         5'd7:    v = 5'd28;
         5'd8:    v = 5'd17;
         5'd9:    v = 5'd6;
         5'd10:   v = 5'd25;
         5'd11:   v = 5'd14;
         5'd12:   v = 5'd3;
         5'd13:   v = 5'd22;
         5'd14:   v = 5'd11;
         5'd15:   v = 5'd0;
         5'd16:   v = 5'd19;
         5'd17:   v = 5'd8;
         5'd18:   v = 5'd27;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

   // x mod 7 by folding 3-bit groups (8 == 1 mod 7)
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
      s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
      s3 = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
      return s3[2:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ofdf_front.sv =====
`default_nettype none

module ofdf_front #(
   parameter int FIXED_FEASTS = ofdf_pkg::FIXED_FEASTS_DEF
) (
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ofdf_pkg::YEAR_W-1:0]  req_year,
   input  wire logic [ofdf_pkg::MONTH_W-1:0] req_month,
   input  wire logic [ofdf_pkg::DAY_W-1:0]   req_day,
   input  wire ofdf_pkg::ofdf_qstat_type     qstat,
   output logic                              push,
   output ofdf_pkg::ofdf_item_type           item
);
   import ofdf_pkg::*;

   logic [27:0]        prod19;
   logic [27:0]        prod7;
   logic [27:0]        prod25;
   logic [FIXED_W-1:0] fixed;

   assign req_ready = !qstat.full;
   assign push      = req_valid && !qstat.full;

   // Quotient estimates: exact or one low, corrected in the back
   assign prod19 = {16'b0, req_year} * RECIP_19;
   assign prod7  = {16'b0, req_year} * RECIP_7;
   assign prod25 = {16'b0, req_year} * RECIP_25;

   // Fixed feast search; lowest matching index wins
   always_comb begin
      fixed = FIXED_NONE;
      for (int i = FIXED_FEASTS - 1; i >= 0; i--) begin
         if (req_month != '0 && req_day != '0 &&
             FEAST_TABLE[i].mon == req_month && FEAST_TABLE[i].mday == req_day) begin
            fixed = FIXED_W'(i + 1);
         end
      end
   end

   always_comb begin
      item.year  = req_year;
      item.month = req_month;
      item.day   = req_day;
      item.q19   = prod19[RECIP_SHIFT +: 8];
      item.q7    = prod7[RECIP_SHIFT +: 10];
      item.q25   = prod25[RECIP_SHIFT +: 8];
      item.fixed = fixed;
   end

endmodule

`default_nettype wire

// ===== rtl/ofdf_queue.sv =====
`default_nettype none

module ofdf_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ofdf_pkg::ofdf_item_type push_item,
   output ofdf_pkg::ofdf_qstat_type     qstat,
   input  wire logic                    pop,
   output logic                         head_valid,
   output ofdf_pkg::ofdf_item_type      head_item
);
   import ofdf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ofdf_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign qstat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_valid  = !qstat.empty;
   assign head_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/ofdf_back.sv =====
`default_nettype none

module ofdf_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire ofdf_pkg::ofdf_item_type       head_item,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ofdf_pkg::MOV_W-1:0]         rsp_movable_feast,
   output logic [ofdf_pkg::FIXED_W-1:0]       rsp_fixed_feast,
   output logic [ofdf_pkg::EMON_W-1:0]        rsp_easter_month,
   output logic [ofdf_pkg::DAY_W-1:0]         rsp_easter_day
);
   import ofdf_pkg::*;

   // Stage one
   logic           s1_valid_ff, s1_valid_in;
   ofdf_stage_type s1_ff, s1_in;
   logic           s1_adv;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic [MOV_W-1:0]   mov_ff, mov_in;
   logic [FIXED_W-1:0] fix_ff, fix_in;
   logic [EMON_W-1:0]  emon_ff, emon_in;
   logic [DAY_W-1:0]   eday_ff, eday_in;
   logic               out_adv;

   logic [YEAR_W-1:0] mul19, mul7, mul25;
   logic [YEAR_W-1:0] r19_raw, r7_raw, r25_raw;
   logic [4:0]        r19, r25;
   logic [2:0]        r7;
   logic              leap;
   logic              month_ok;

   logic [6:0]         esum;
   logic [2:0]         e;
   logic [6:0]         k;
   logic [7:0]         edoy;
   logic signed [9:0]  diff;

   assign out_adv = !out_valid_ff || rsp_ready;
   assign s1_adv  = !s1_valid_ff || out_adv;
   assign pop     = head_valid && s1_adv;

   // Stage one: finish the residues, leap year, date check, day of year
   always_comb begin
      mul19   = YEAR_W'({4'b0, head_item.q19} * 12'd19);
      mul7    = YEAR_W'({2'b0, head_item.q7} * 12'd7);
      mul25   = YEAR_W'({4'b0, head_item.q25} * 12'd25);
      r19_raw = head_item.year - mul19;
      r7_raw  = head_item.year - mul7;
      r25_raw = head_item.year - mul25;
      r19     = (r19_raw >= 12'd19) ? 5'(r19_raw - 12'd19) : 5'(r19_raw);
      r7      = (r7_raw >= 12'd7) ? 3'(r7_raw - 12'd7) : 3'(r7_raw);
      r25     = (r25_raw >= 12'd25) ? 5'(r25_raw - 12'd25) : 5'(r25_raw);
      // divisible by 100 is divisible by 4 and 25; by 400 also by 16
      leap    = (head_item.year[1:0] == 2'b00) &&
                ((r25 != 5'd0) || (head_item.year[3:0] == 4'b0000));
      month_ok = head_item.month inside {[4'd1:4'd12]};

      s1_in.d       = d_of(r19);
      s1_in.b       = head_item.year[1:0];
      s1_in.c       = r7;
      s1_in.leap    = leap;
      s1_in.date_ok = month_ok && (head_item.day != '0) &&
                      (head_item.day <= month_len(head_item.month, leap));
      s1_in.doy     = days_before(head_item.month) + DOY_W'(head_item.day) +
                      DOY_W'(leap && (head_item.month > MON_FEB));
      s1_in.fixed   = head_item.fixed;
      s1_valid_in   = s1_adv ? head_valid : s1_valid_ff;
   end

   // Stage two: e, Easter date, offset match
   always_comb begin
      esum = 7'(s1_ff.b) + 7'({s1_ff.c, 1'b0}) + 7'({s1_ff.d, 1'b0}) +
             7'(s1_ff.d) + 7'd3;
      e    = mod7({esum, 1'b0});
      k    = 7'd34 + 7'(s1_ff.d) + 7'(e);
      edoy = 8'd60 + 8'(s1_ff.leap) + 8'(k);
      diff = $signed({1'b0, s1_ff.doy}) - $signed({2'b00, edoy});

      if (k < 7'd61) begin
         emon_in = MON_APRIL;
         eday_in = 5'(k - 7'd30);
      end else begin
         emon_in = MON_MAY;
         eday_in = 5'(k - 7'd60);
      end

      mov_in = MOV_NONE;
      if (s1_ff.date_ok) begin
         case (diff)
            10'sd0:   mov_in = MOV_EASTER;
            -10'sd48: mov_in = MOV_M48;
            -10'sd47: mov_in = MOV_M47;
            -10'sd7:  mov_in = MOV_M7;
            10'sd39:  mov_in = MOV_P39;
            10'sd49:  mov_in = MOV_P49;
            10'sd57:  mov_in = MOV_P57;
            default:  mov_in = MOV_NONE;
         endcase
      end
      fix_in       = s1_ff.date_ok ? s1_ff.fixed : FIXED_NONE;
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= s1_in;
      end
      if (out_adv && s1_valid_ff) begin
         mov_ff  <= mov_in;
         fix_ff  <= fix_in;
         emon_ff <= emon_in;
         eday_ff <= eday_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_movable_feast = mov_ff;
   assign rsp_fixed_feast   = fix_ff;
   assign rsp_easter_month  = emon_ff;
   assign rsp_easter_day    = eday_ff;

`ifndef SYNTHESIS
   a_emon_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (emon_ff == MON_APRIL || emon_ff == MON_MAY))
      else $error("Easter month out of range");
   a_eday_april: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && emon_ff == MON_APRIL) |-> (eday_ff >= 5'd4 && eday_ff <= 5'd30))
      else $error("April Easter day out of range");
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_adv) |=> s1_valid_ff && $stable(s1_ff))
      else $error("stage one lost an item under stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/orthodox_feast_day_finder_core.sv =====
`default_nettype none

// Orthodox feast day finder. Each request carries a Gregorian date (year,
// month, day); each response gives the Orthodox Easter month and day of that
// year (Meeus Julian formula with the +13 day Gregorian shift, valid for
// 1900..2099), the movable feast code of the date (0 none, 1 Easter, 2..7 for
// Easter -48, -47, -7, +39, +49, +57 days) and the 1-based index of the
// matching fixed feast (0 none). An impossible date matches no feast but
// still reports Easter. One response per request, in order. A request is
// taken every cycle while the queue is not full, and passes through the
// queue, stage one register and response register. The front estimates
// the year quotients with reciprocal multiplies and looks up the fixed
// feast table, a two-entry queue parts it from the back, and the back runs
// stage one (residues, day of year) and stage two (Easter, offset match);
// up to four requests are held while rsp_ready is low.
module orthodox_feast_day_finder_core #(
   parameter int FIXED_FEASTS = ofdf_pkg::FIXED_FEASTS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ofdf_pkg::YEAR_W-1:0]  req_year,
   input  wire logic [ofdf_pkg::MONTH_W-1:0] req_month,
   input  wire logic [ofdf_pkg::DAY_W-1:0]   req_day,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [ofdf_pkg::MOV_W-1:0]        rsp_movable_feast,
   output logic [ofdf_pkg::FIXED_W-1:0]      rsp_fixed_feast,
   output logic [ofdf_pkg::EMON_W-1:0]       rsp_easter_month,
   output logic [ofdf_pkg::DAY_W-1:0]        rsp_easter_day
);
   import ofdf_pkg::*;

   logic           push;
   logic           pop;
   logic           head_valid;
   ofdf_item_type  push_item;
   ofdf_item_type  head_item;
   ofdf_qstat_type qstat;

   // Front: take the transfer, estimate quotients, match the fixed table
   ofdf_front #(
      .FIXED_FEASTS (FIXED_FEASTS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_year  (req_year),
      .req_month (req_month),
      .req_day   (req_day),
      .qstat     (qstat),
      .push      (push),
      .item      (push_item)
   );

   // Queue: hold classified items while the back stalls
   ofdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .qstat      (qstat),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back: compute Easter, match the movable offsets, drive the response
   ofdf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_movable_feast (rsp_movable_feast),
      .rsp_fixed_feast   (rsp_fixed_feast),
      .rsp_easter_month  (rsp_easter_month),
      .rsp_easter_day    (rsp_easter_day)
   );

endmodule

`default_nettype wire
